@@ design/jh2d_pkg.sv @@
// Package for the joint 2D histogram: sizes, op codes, register indexes, sequencer states.
// No dependencies; imported by the channel interfaces and the top level.
package jh2d_pkg;

    localparam int MAX_BINS  = 64;
    localparam int COUNT_W   = 32;
    localparam int VALUE_W   = 32;
    localparam int BIN_W     = $clog2(MAX_BINS);
    localparam int BINS_W    = BIN_W + 1;
    localparam int DEPTH     = MAX_BINS * MAX_BINS;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int NUM_W     = VALUE_W + BINS_W;
    localparam int DIV_CNT_W = (BIN_W > 1) ? $clog2(BIN_W) : 1;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BINS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_MIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_MAX  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_BINS = 3'd5;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIFF,
        S_MUL,
        S_DIV,
        S_READ,
        S_UPDATE,
        S_FINISH
    } state_t;

endpackage

@@ design/jh2d_req_if.sv @@
// Request channel of the joint 2D histogram: op and sample or bin address.
// Depends on jh2d_pkg.
interface jh2d_req_if import jh2d_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] first_value;
    logic signed [VALUE_W-1:0] second_value;
    logic [BIN_W-1:0]          read_row;
    logic [BIN_W-1:0]          read_col;

    modport source (output valid, op, first_value, second_value, read_row, read_col,
                    input ready);
    modport sink (input valid, op, first_value, second_value, read_row, read_col,
                  output ready);
endinterface

@@ design/jh2d_rsp_if.sv @@
// Response channel of the joint 2D histogram: hit flag, bins and count.
// Depends on jh2d_pkg.
interface jh2d_rsp_if import jh2d_pkg::*;;
    logic               valid;
    logic               ready;
    logic               hit;
    logic [BIN_W-1:0]   row_bin;
    logic [BIN_W-1:0]   col_bin;
    logic [COUNT_W-1:0] bin_count;

    modport source (output valid, hit, row_bin, col_bin, bin_count, input ready);
    modport sink (input valid, hit, row_bin, col_bin, bin_count, output ready);
endinterface

@@ design/joint_histogram_2d.sv @@
// Joint 2D histogram top level: config registers, sequencer, divider steps, count memory.
// Depends on jh2d_pkg, jh2d_req_if and jh2d_rsp_if.
//
//  channel  dir  contents
//  req      in   op, first_value, second_value, read_row, read_col
//  rsp      out  hit, row_bin, col_bin, bin_count
//  cfg      in   cfg_we, cfg_index, cfg_data (write only)
//
// Add with hit: difference, multiply, the six one-bit steps of the bin divider per axis,
// then the read-modify-write of the single-port count memory, then the result beat.
// Add without hit: difference, then the result. Read: memory read, then the result.
// Unused op: straight to the result. Clear: a pass over all 4096 memory entries, one
// entry a cycle, then the result beat. After reset the same pass runs with req.ready low
// and gives no beat. A result waiting on rsp.ready holds the sequencer in its last state.
module joint_histogram_2d import jh2d_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    jh2d_req_if.sink              req,
    jh2d_rsp_if.source            rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    state_t state_reg, state_next;

    logic signed [VALUE_W-1:0] first_min_reg, first_max_reg;
    logic signed [VALUE_W-1:0] second_min_reg, second_max_reg;
    logic [BINS_W-1:0]         first_bins_reg, second_bins_reg;

    logic [OP_W-1:0]           op_reg;
    logic signed [VALUE_W-1:0] fv_reg, sv_reg;
    logic [VALUE_W-1:0]        df_reg, ds_reg, dvf_reg, dvs_reg;
    logic [NUM_W-1:0]          numf_reg, nums_reg, dshf_reg, dshs_reg;
    logic [BIN_W-1:0]          qf_reg, qs_reg;
    logic [DIV_CNT_W-1:0]      div_cnt_reg;
    logic [ADDR_W-1:0]         addr_reg;
    logic [ADDR_W-1:0]         clr_cnt_reg;
    logic                      clr_reply_reg;
    logic [COUNT_W-1:0]        rdata_reg;

    logic                      out_valid_reg;
    logic                      out_hit_reg;
    logic [BIN_W-1:0]          out_row_reg, out_col_reg;
    logic [COUNT_W-1:0]        out_count_reg;

    logic [COUNT_W-1:0]        mem [DEPTH];

    logic [BINS_W-1:0]  bins_f_eff, bins_s_eff;
    logic               hit_f, hit_s;
    logic               ge_f, ge_s;
    logic [NUM_W-1:0]   numf_step, nums_step;
    logic [BIN_W-1:0]   qf_step, qs_step;
    logic               div_last;
    logic               slot_free;
    logic               load_out;
    logic               accept;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [COUNT_W-1:0] mem_wdata;
    logic [COUNT_W-1:0] count_new;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_min_reg   <= '0;
            first_max_reg   <= VALUE_W'(65536);
            first_bins_reg  <= BINS_W'(64);
            second_min_reg  <= '0;
            second_max_reg  <= VALUE_W'(65536);
            second_bins_reg <= BINS_W'(64);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FIRST_MIN:   first_min_reg   <= cfg_data[VALUE_W-1:0];
                CFG_FIRST_MAX:   first_max_reg   <= cfg_data[VALUE_W-1:0];
                CFG_FIRST_BINS:  first_bins_reg  <= cfg_data[BINS_W-1:0];
                CFG_SECOND_MIN:  second_min_reg  <= cfg_data[VALUE_W-1:0];
                CFG_SECOND_MAX:  second_max_reg  <= cfg_data[VALUE_W-1:0];
                CFG_SECOND_BINS: second_bins_reg <= cfg_data[BINS_W-1:0];
                default: ;
            endcase
        end
    end

    assign bins_f_eff = (first_bins_reg > BINS_W'(MAX_BINS)) ? BINS_W'(MAX_BINS)
                                                              : first_bins_reg;
    assign bins_s_eff = (second_bins_reg > BINS_W'(MAX_BINS)) ? BINS_W'(MAX_BINS)
                                                               : second_bins_reg;

    assign hit_f = (bins_f_eff != '0) && (first_max_reg > first_min_reg) &&
                   (fv_reg >= first_min_reg) && (fv_reg < first_max_reg);
    assign hit_s = (bins_s_eff != '0) && (second_max_reg > second_min_reg) &&
                   (sv_reg >= second_min_reg) && (sv_reg < second_max_reg);

    // one quotient bit per axis per cycle; quotient is below the bin count
    assign ge_f      = numf_reg >= dshf_reg;
    assign ge_s      = nums_reg >= dshs_reg;
    assign numf_step = ge_f ? numf_reg - dshf_reg : numf_reg;
    assign nums_step = ge_s ? nums_reg - dshs_reg : nums_reg;
    assign qf_step   = {qf_reg[BIN_W-2:0], ge_f};
    assign qs_step   = {qs_reg[BIN_W-2:0], ge_s};
    assign div_last  = div_cnt_reg == DIV_CNT_W'(BIN_W - 1);

    assign slot_free = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign count_new = (rdata_reg == '1) ? rdata_reg : rdata_reg + COUNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req.ready  = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = clr_reply_reg ? S_FINISH : S_IDLE;
                end
            end
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    case (req.op)
                        OP_ADD:   state_next = S_DIFF;
                        OP_READ:  state_next = S_READ;
                        OP_CLEAR: state_next = S_CLEAR;
                        default:  state_next = S_FINISH;
                    endcase
                end
            end
            S_DIFF:
            begin
                state_next = (hit_f && hit_s) ? S_MUL : S_FINISH;
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_last)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE, S_FINISH:
            begin
                if (slot_free)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            clr_reply_reg <= 1'b0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (accept && req.op == OP_CLEAR)
            begin
                clr_reply_reg <= 1'b1;
            end
            if (state_reg == S_DIV)
            begin
                div_cnt_reg <= div_last ? '0 : div_cnt_reg + DIV_CNT_W'(1);
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= req.op;
            fv_reg   <= req.first_value;
            sv_reg   <= req.second_value;
            addr_reg <= {req.read_row, req.read_col};
        end
        if (state_reg == S_DIFF)
        begin
            df_reg  <= fv_reg - first_min_reg;
            ds_reg  <= sv_reg - second_min_reg;
            dvf_reg <= first_max_reg - first_min_reg;
            dvs_reg <= second_max_reg - second_min_reg;
        end
        if (state_reg == S_MUL)
        begin
            numf_reg <= NUM_W'(df_reg) * NUM_W'(bins_f_eff);
            nums_reg <= NUM_W'(ds_reg) * NUM_W'(bins_s_eff);
            dshf_reg <= NUM_W'(dvf_reg) << (BIN_W - 1);
            dshs_reg <= NUM_W'(dvs_reg) << (BIN_W - 1);
            qf_reg   <= '0;
            qs_reg   <= '0;
        end
        if (state_reg == S_DIV)
        begin
            numf_reg <= numf_step;
            nums_reg <= nums_step;
            dshf_reg <= dshf_reg >> 1;
            dshs_reg <= dshs_reg >> 1;
            qf_reg   <= qf_step;
            qs_reg   <= qs_step;
            if (div_last)
            begin
                addr_reg <= {qf_step, qs_step};
            end
        end
        if (load_out)
        begin
            if (state_reg == S_UPDATE && op_reg == OP_ADD)
            begin
                out_hit_reg   <= 1'b1;
                out_row_reg   <= addr_reg[ADDR_W-1:BIN_W];
                out_col_reg   <= addr_reg[BIN_W-1:0];
                out_count_reg <= count_new;
            end
            else if (state_reg == S_UPDATE)
            begin
                out_hit_reg   <= 1'b0;
                out_row_reg   <= '0;
                out_col_reg   <= '0;
                out_count_reg <= rdata_reg;
            end
            else
            begin
                out_hit_reg   <= 1'b0;
                out_row_reg   <= '0;
                out_col_reg   <= '0;
                out_count_reg <= '0;
            end
        end
    end

    // count memory, one read-modify-write in flight at a time
    assign mem_we    = (state_reg == S_CLEAR) ||
                       (state_reg == S_UPDATE && slot_free && op_reg == OP_ADD);
    assign mem_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg : addr_reg;
    assign mem_wdata = (state_reg == S_CLEAR) ? '0 : count_new;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == S_READ)
        begin
            rdata_reg <= mem[addr_reg];
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.hit       = out_hit_reg;
    assign rsp.row_bin   = out_row_reg;
    assign rsp.col_bin   = out_col_reg;
    assign rsp.bin_count = out_count_reg;

    a_clear_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !req.ready)
        else $error("request taken during clearing pass");

    a_write_only_on_add: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg != S_CLEAR) |-> (op_reg == OP_ADD && state_reg == S_UPDATE))
        else $error("count write outside an add update");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.hit) |-> ({1'b0, rsp.row_bin} < bins_f_eff &&
                                    {1'b0, rsp.col_bin} < bins_s_eff))
        else $error("bin beyond configured bin count");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && !div_last) |=> state_reg == S_DIV)
        else $error("divider left early");

endmodule

@@ dv/tb.sv @@
// Self-checking bench for joint_histogram_2d: directed table, then randomised phases.
// The count store mirror predicts each untyped result beat; random stalls on both sides.
// Depends on jh2d_pkg, jh2d_req_if, jh2d_rsp_if and the joint_histogram_2d RTL.
module tb import jh2d_pkg::*;;

    localparam logic [OP_W-1:0]      OP_NONE         = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED      = 3'd7;
    localparam int                   QUIET_LIMIT     = 20000;
    localparam int                   HOLD_OFF_CYCLES = 300;
    localparam int                   PLAN_LEN        = 19;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] first_value;
        logic [VALUE_W-1:0] second_value;
        logic [BIN_W-1:0]   read_row;
        logic [BIN_W-1:0]   read_col;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic [BIN_W-1:0]   row_bin;
        logic [BIN_W-1:0]   col_bin;
        logic [COUNT_W-1:0] bin_count;
    } tally_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] fv;
        logic [VALUE_W-1:0] sv;
        logic [BIN_W-1:0]   rr;
        logic [BIN_W-1:0]   rc;
        logic               typed;
        logic               hit;
        logic [BIN_W-1:0]   rbin;
        logic [BIN_W-1:0]   cbin;
        logic [COUNT_W-1:0] cnt;
    } step_t;

    // reset config: 1024 per bin on both axes
    step_t plan [PLAN_LEN] = '{
        '{OP_READ,  32'h0000_0000, 32'h0000_0000, 6'd0,  6'd0,  1'b1, 1'b0, 6'd0,  6'd0,  32'd0},
        '{OP_ADD,   32'h0000_0000, 32'h0000_0000, 6'd0,  6'd0,  1'b1, 1'b1, 6'd0,  6'd0,  32'd1},
        '{OP_ADD,   32'h0000_FFFF, 32'h0000_FFFF, 6'd0,  6'd0,  1'b1, 1'b1, 6'd63, 6'd63, 32'd1},
        '{OP_ADD,   32'h0001_0000, 32'h0000_0000, 6'd0,  6'd0,  1'b1, 1'b0, 6'd0,  6'd0,  32'd0},
        '{OP_ADD,   32'hFFFF_FFFF, 32'h0000_0000, 6'd0,  6'd0,  1'b1, 1'b0, 6'd0,  6'd0,  32'd0},
        '{OP_ADD,   32'h7FFF_FFFF, 32'h8000_0000, 6'd0,  6'd0,  1'b1, 1'b0, 6'd0,  6'd0,  32'd0},
        '{OP_ADD,   32'h8000_0000, 32'h7FFF_FFFF, 6'd0,  6'd0,  1'b1, 1'b0, 6'd0,  6'd0,  32'd0},
        '{OP_ADD,   32'h0000_0000, 32'h0000_03FF, 6'd0,  6'd0,  1'b1, 1'b1, 6'd0,  6'd0,  32'd2},
        '{OP_READ,  32'h0000_0000, 32'h0000_0000, 6'd0,  6'd0,  1'b1, 1'b0, 6'd0,  6'd0,  32'd2},
        '{OP_READ,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 6'd63, 1'b1, 1'b0, 6'd0,  6'd0,  32'd1},
        '{OP_READ,  32'h0000_0000, 32'h0000_0000, 6'd63, 6'd0,  1'b1, 1'b0, 6'd0,  6'd0,  32'd0},
        '{OP_NONE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 6'd63, 1'b1, 1'b0, 6'd0,  6'd0,  32'd0},
        '{OP_ADD,   32'h0000_8123, 32'h0000_5A5A, 6'd0,  6'd0,  1'b0, 1'b0, 6'd0,  6'd0,  32'd0},
        '{OP_ADD,   32'h0000_0400, 32'h0000_0800, 6'd0,  6'd0,  1'b1, 1'b1, 6'd1,  6'd2,  32'd1},
        '{OP_READ,  32'h0000_0000, 32'h0000_0000, 6'd1,  6'd2,  1'b1, 1'b0, 6'd0,  6'd0,  32'd1},
        '{OP_CLEAR, 32'h0000_0000, 32'h0000_0000, 6'd63, 6'd63, 1'b1, 1'b0, 6'd0,  6'd0,  32'd0},
        '{OP_READ,  32'h0000_0000, 32'h0000_0000, 6'd63, 6'd63, 1'b1, 1'b0, 6'd0,  6'd0,  32'd0},
        '{OP_READ,  32'h0000_0000, 32'h0000_0000, 6'd1,  6'd2,  1'b1, 1'b0, 6'd0,  6'd0,  32'd0},
        '{OP_ADD,   32'h0000_8123, 32'h0000_5A5A, 6'd0,  6'd0,  1'b0, 1'b0, 6'd0,  6'd0,  32'd0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    jh2d_req_if req_if();
    jh2d_rsp_if rsp_if();

    joint_histogram_2d u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // mirror of the block's registers and count store
    logic signed [VALUE_W-1:0] lo_a, hi_a, lo_b, hi_b;
    logic [BINS_W-1:0]         bins_a, bins_b;
    logic [COUNT_W-1:0]        mirror_counts [DEPTH];
    logic [2*BIN_W-1:0]        hit_cells [$];
    tally_t                    pending_tallies [$];

    int  mismatches = 0;
    int  gap_odds   = 0;
    bit  hold_off   = 1'b0;
    int  n_adds = 0, n_hits = 0, n_reads = 0, n_clears = 0, n_other = 0, n_settings = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit axis_slot(input logic signed [VALUE_W-1:0] v, lo, hi,
                                     input logic [BINS_W-1:0] nbins,
                                     output logic [BIN_W-1:0] slot);
        longint lv, llo, lhi, n;
        lv  = v;
        llo = lo;
        lhi = hi;
        n   = (nbins > MAX_BINS) ? longint'(MAX_BINS) : longint'(nbins);
        slot = '0;
        if (n == 0 || lhi <= llo || lv < llo || lv >= lhi)
            return 1'b0;
        slot = BIN_W'((lv - llo) * n / (lhi - llo));
        return 1'b1;
    endfunction

    function automatic tally_t predict_tally(input req_t it);
        tally_t             t;
        logic [BIN_W-1:0]   r, c;
        bit                 in_a, in_b;
        logic [ADDR_W-1:0]  at;
        t = '0;
        case (it.op)
            OP_ADD:
            begin
                n_adds++;
                in_a = axis_slot(it.first_value, lo_a, hi_a, bins_a, r);
                in_b = axis_slot(it.second_value, lo_b, hi_b, bins_b, c);
                if (in_a && in_b)
                begin
                    at = {r, c};
                    if (mirror_counts[at] != '1)
                        mirror_counts[at] = mirror_counts[at] + 1'b1;
                    t.hit       = 1'b1;
                    t.row_bin   = r;
                    t.col_bin   = c;
                    t.bin_count = mirror_counts[at];
                    hit_cells.push_back({r, c});
                    if (hit_cells.size() > 32)
                        void'(hit_cells.pop_front());
                    n_hits++;
                end
            end
            OP_READ:
            begin
                n_reads++;
                t.bin_count = mirror_counts[{it.read_row, it.read_col}];
            end
            OP_CLEAR:
            begin
                n_clears++;
                foreach (mirror_counts[i])
                    mirror_counts[i] = '0;
                hit_cells.delete();
            end
            default:
                n_other++;
        endcase
        return t;
    endfunction

    // mostly in range, some on the edges, the rest anywhere
    function automatic logic [VALUE_W-1:0] pick_value(input logic signed [VALUE_W-1:0] lo, hi);
        longint          span;
        longint unsigned r64;
        int              roll;
        span = longint'(hi) - longint'(lo);
        roll = $urandom_range(0, 9);
        r64  = {$urandom, $urandom};
        if (span <= 0 || roll >= 8)
            return VALUE_W'($urandom);
        if (roll == 7)
        begin
            case ($urandom_range(0, 3))
                0: return lo;
                1: return lo - 32'sd1;
                2: return hi;
                default: return hi - 32'sd1;
            endcase
        end
        return VALUE_W'(longint'(lo) + longint'(r64 % longint'(span)));
    endfunction

    function automatic req_t make_item(input bit clears);
        req_t it;
        int   roll;
        roll = $urandom_range(0, 199);
        it.op           = OP_ADD;
        it.first_value  = VALUE_W'($urandom);
        it.second_value = VALUE_W'($urandom);
        it.read_row     = BIN_W'($urandom);
        it.read_col     = BIN_W'($urandom);
        if (clears && roll < 2)
            it.op = OP_CLEAR;
        else if (roll < 6)
            it.op = OP_NONE;
        else if (roll < 70)
        begin
            it.op = OP_READ;
            if (hit_cells.size() != 0 && $urandom_range(0, 2) != 0)
                {it.read_row, it.read_col} = hit_cells[$urandom_range(0, hit_cells.size() - 1)];
        end
        else
        begin
            it.first_value  = pick_value(lo_a, hi_a);
            it.second_value = pick_value(lo_b, hi_b);
        end
        return it;
    endfunction

    function automatic void check_field(input string name, input longint unsigned want, got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_item(input req_t it, input bit typed, input tally_t typed_tally);
        tally_t want;
        if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0)
        begin
            req_if.valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        req_if.valid        = 1'b1;
        req_if.op           = it.op;
        req_if.first_value  = it.first_value;
        req_if.second_value = it.second_value;
        req_if.read_row     = it.read_row;
        req_if.read_col     = it.read_col;
        do
            @(posedge clk);
        while (!req_if.ready);
        want = predict_tally(it);
        pending_tallies.push_back(typed ? typed_tally : want);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_if.valid = 1'b0;
        while (pending_tallies.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_FIRST_MIN:   lo_a   = data;
            CFG_FIRST_MAX:   hi_a   = data;
            CFG_FIRST_BINS:  bins_a = data[BINS_W-1:0];
            CFG_SECOND_MIN:  lo_b   = data;
            CFG_SECOND_MAX:  hi_b   = data;
            CFG_SECOND_BINS: bins_b = data[BINS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] la, ha, ba, lb, hb, bb);
        wait_drained();
        write_reg(CFG_FIRST_MIN, la);
        write_reg(CFG_FIRST_MAX, ha);
        write_reg(CFG_FIRST_BINS, ba);
        write_reg(CFG_SECOND_MIN, lb);
        write_reg(CFG_SECOND_MAX, hb);
        write_reg(CFG_SECOND_BINS, bb);
        n_settings++;
    endtask

    task automatic run_phase(input int n_items, input bit clears, input int odds);
        tally_t none;
        none     = '0;
        gap_odds = odds;
        repeat (n_items)
            send_item(make_item(clears), 1'b0, none);
    endtask

    task automatic random_edges(output logic [CFG_DATA_W-1:0] lo, hi);
        logic signed [VALUE_W-1:0] s;
        longint                    l, h;
        s = VALUE_W'($urandom);
        l = s;
        if ($urandom_range(0, 2) == 0)
            h = l + longint'($urandom) + 1;
        else
            h = l + longint'($urandom_range(1, 65536));
        if (h > 64'sd2147483647)
            h = 64'sd2147483647;
        lo = l[CFG_DATA_W-1:0];
        hi = h[CFG_DATA_W-1:0];
    endtask

    // result side: random stall bursts, plus one long hold-off on request
    initial
    begin : result_ready
        int stall;
        stall = 0;
        rsp_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                hold_off     = 1'b0;
                rsp_if.ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            if (stall > 0)
            begin
                stall--;
                rsp_if.ready = 1'b0;
            end
            else if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0)
            begin
                stall = $urandom_range(1, 11) - 1;
                rsp_if.ready = 1'b0;
            end
            else
                rsp_if.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        tally_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_tallies.size() == 0)
            begin
                $error("result beat with nothing outstanding");
                mismatches++;
            end
            else
            begin
                want = pending_tallies.pop_front();
                check_field("hit", want.hit, rsp_if.hit);
                check_field("row_bin", want.row_bin, rsp_if.row_bin);
                check_field("col_bin", want.col_bin, rsp_if.col_bin);
                check_field("bin_count", want.bin_count, rsp_if.bin_count);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("joint_histogram_2d: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        req_t                  it;
        tally_t                typed_tally;
        logic [CFG_DATA_W-1:0] la, ha, lb, hb;
        int                    odds [5];

        odds = '{0, 3, 8, 12, 5};
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        req_if.valid        = 1'b0;
        req_if.op           = OP_ADD;
        req_if.first_value  = '0;
        req_if.second_value = '0;
        req_if.read_row     = '0;
        req_if.read_col     = '0;
        lo_a   = 32'sd0;
        hi_a   = 32'sd65536;
        bins_a = 7'd64;
        lo_b   = 32'sd0;
        hi_b   = 32'sd65536;
        bins_b = 7'd64;
        foreach (mirror_counts[i])
            mirror_counts[i] = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        gap_odds = 5;
        foreach (plan[i])
        begin
            it.op           = plan[i].op;
            it.first_value  = plan[i].fv;
            it.second_value = plan[i].sv;
            it.read_row     = plan[i].rr;
            it.read_col     = plan[i].rc;
            typed_tally     = {plan[i].hit, plan[i].rbin, plan[i].cbin, plan[i].cnt};
            send_item(it, plan[i].typed, typed_tally);
        end

        // widest ranges, a single bin on the second axis
        set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'd64, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1);
        run_phase(80, 1'b1, 4);

        // empty first range, zero bins on the second axis; unused index is harmless
        set_config(32'd100, 32'd100, 32'd64, 32'hFFFF_FFFB, 32'd5, 32'd0);
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        run_phase(30, 1'b0, 6);
        set_config(32'd5, 32'hFFFF_FFFB, 32'd1, 32'd0, 32'd65536, 32'd64);
        run_phase(20, 1'b0, 0);

        // bin counts above the maximum, long result hold-off while requests keep coming
        set_config(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_FFFF, 32'hFFFF_FC18, 32'd3000, 32'd100);
        hold_off = 1'b1;
        run_phase(100, 1'b1, 6);

        for (int p = 0; p < 5; p++)
        begin
            random_edges(la, ha);
            random_edges(lb, hb);
            set_config(la, ha,
                       ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 64),
                       lb, hb,
                       ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 64));
            run_phase(80, 1'b1, odds[p]);
        end

        // closing stretch at full rate
        random_edges(la, ha);
        random_edges(lb, hb);
        set_config(la, ha, $urandom_range(1, 64), lb, hb, $urandom_range(1, 64));
        run_phase(110, 1'b1, 0);

        wait_drained();
        repeat (20) @(posedge clk);

        $display("covered %0d adds (%0d in range), %0d reads, %0d clears, %0d unused ops",
                 n_adds, n_hits, n_reads, n_clears, n_other);
        $display("across %0d register settings with stalls on both channels", n_settings);
        if (mismatches == 0)
            $display("joint_histogram_2d: match");
        else
            $display("joint_histogram_2d: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
design/jh2d_pkg.sv
design/jh2d_req_if.sv
design/jh2d_rsp_if.sv
design/joint_histogram_2d.sv
dv/tb.sv
